>>> rtl/json_string_unescaper_top_assert.svh
// Assertion macros shared by the unescaper modules.
// Each expects clk and rst_n in scope.
`ifndef JSON_STRING_UNESCAPER_TOP_ASSERT_SVH
`define JSON_STRING_UNESCAPER_TOP_ASSERT_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsu assertion failed");

// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsu assertion failed");

`endif

>>> rtl/jsu_pkg.sv
package jsu_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned MAX_OUT    = 6;
  localparam logic [15:0] CAP_RESET  = 16'd64;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6e;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;

  typedef enum logic [3:0] {
    PH_SEEK,
    PH_BODY,
    PH_ESC,
    PH_U,
    PH_HELD,
    PH_HELD_ESC,
    PH_HELD_U,
    PH_DONE,
    PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  // one decoded input byte: up to six stored bytes
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [2:0]              cnt;
    status_t                 status;
    logic [15:0]             base;
  } entry_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.b[0] = cp[7:0];
      r.len  = 3'd1;
    end else if (cp < 21'h800) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.len  = 3'd2;
    end else if (cp < 21'h10000) begin
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
      r.len  = 3'd3;
    end else begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.len  = 3'd4;
    end
    return r;
  endfunction

  function automatic hex_t hex_dec(input logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.val = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

>>> rtl/jsu_fifo.sv
`include "json_string_unescaper_top_assert.svh"

module jsu_fifo #(
  parameter int unsigned DEPTH = jsu_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jsu_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output jsu_pkg::entry_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jsu_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  `JSU_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CW'(DEPTH))
  `JSU_ASSERT_NEXT(a_cnt_grow, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

>>> rtl/jsu_front.sv
`include "json_string_unescaper_top_assert.svh"

module jsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [15:0]     cap,
  input  logic            in_beat_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_first_byte,
  input  logic            in_last_byte,
  input  logic            fifo_full,
  output logic            push,
  output jsu_pkg::entry_t push_entry
);

  jsu_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     acc_r, acc_nxt;
  logic [15:0]     held_r, held_nxt;
  logic [1:0]      dig_r, dig_nxt;
  logic [15:0]     stored_r, stored_nxt;

  jsu_pkg::phase_t ph;
  logic [15:0]     acc, held, stored;
  logic [1:0]      dig;
  jsu_pkg::hex_t   hx;
  logic [15:0]     acc_sh;
  logic            lo_high, lo_low;
  logic            esc_ok, esc_u;
  logic [7:0]      esc_val;
  logic            s1_en, s2_en, s2_raw;
  logic [20:0]     cp2;
  jsu_pkg::utf8_t  e1, e2;
  logic [2:0]      len1, len2, ntot, kept;
  logic [16:0]     stored_p1, room;
  logic [jsu_pkg::MAX_OUT-1:0][7:0] mb;

  assign in_stall = fifo_full;
  assign push     = in_beat_valid && !fifo_full;

  always_comb begin
    esc_ok  = 1'b1;
    esc_u   = 1'b0;
    esc_val = in_byte;
    case (in_byte)
      jsu_pkg::CH_QUOTE:  esc_val = jsu_pkg::CH_QUOTE;
      jsu_pkg::CH_BSLASH: esc_val = jsu_pkg::CH_BSLASH;
      jsu_pkg::CH_SLASH:  esc_val = jsu_pkg::CH_SLASH;
      jsu_pkg::CH_LC_B:   esc_val = jsu_pkg::CH_BS;
      jsu_pkg::CH_LC_F:   esc_val = jsu_pkg::CH_FF;
      jsu_pkg::CH_LC_N:   esc_val = jsu_pkg::CH_LF;
      jsu_pkg::CH_LC_R:   esc_val = jsu_pkg::CH_CR;
      jsu_pkg::CH_LC_T:   esc_val = jsu_pkg::CH_TAB;
      jsu_pkg::CH_LC_U: begin
        esc_ok = 1'b0;
        esc_u  = 1'b1;
      end
      default: esc_ok = 1'b0;
    endcase
  end

  always_comb begin
    ph     = in_first_byte ? jsu_pkg::PH_SEEK : phase_r;
    acc    = in_first_byte ? 16'h0 : acc_r;
    held   = in_first_byte ? 16'h0 : held_r;
    stored = in_first_byte ? 16'h0 : stored_r;
    dig    = in_first_byte ? 2'd0 : dig_r;

    hx      = jsu_pkg::hex_dec(in_byte);
    acc_sh  = {acc[11:0], hx.val};
    lo_high = acc_sh inside {[16'hd800:16'hdbff]};
    lo_low  = acc_sh inside {[16'hdc00:16'hdfff]};

    phase_nxt = ph;
    acc_nxt   = acc;
    held_nxt  = held;
    dig_nxt   = dig;
    s1_en     = 1'b0;
    s2_en     = 1'b0;
    s2_raw    = 1'b0;
    cp2       = {13'h0, in_byte};

    case (ph)
      jsu_pkg::PH_SEEK: begin
        if (in_byte inside {jsu_pkg::CH_SPACE, jsu_pkg::CH_TAB, jsu_pkg::CH_LF,
                            jsu_pkg::CH_CR}) begin
          phase_nxt = jsu_pkg::PH_SEEK;
        end else if (in_byte == jsu_pkg::CH_QUOTE && cap != 16'h0) begin
          phase_nxt = jsu_pkg::PH_BODY;
        end else begin
          phase_nxt = jsu_pkg::PH_ERR;
        end
      end
      jsu_pkg::PH_BODY, jsu_pkg::PH_HELD: begin
        if (ph == jsu_pkg::PH_HELD && in_byte == jsu_pkg::CH_BSLASH) begin
          phase_nxt = jsu_pkg::PH_HELD_ESC;
        end else begin
          s1_en = (ph == jsu_pkg::PH_HELD);
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            phase_nxt = jsu_pkg::PH_DONE;
          end else if (in_byte == jsu_pkg::CH_BSLASH) begin
            phase_nxt = jsu_pkg::PH_ESC;
          end else begin
            phase_nxt = jsu_pkg::PH_BODY;
            s2_en     = 1'b1;
            s2_raw    = 1'b1;
          end
        end
      end
      jsu_pkg::PH_ESC, jsu_pkg::PH_HELD_ESC: begin
        if (esc_u) begin
          acc_nxt   = 16'h0;
          dig_nxt   = 2'd0;
          phase_nxt = (ph == jsu_pkg::PH_HELD_ESC) ? jsu_pkg::PH_HELD_U : jsu_pkg::PH_U;
        end else begin
          s1_en = (ph == jsu_pkg::PH_HELD_ESC);
          if (esc_ok) begin
            s2_en     = 1'b1;
            cp2       = {13'h0, esc_val};
            phase_nxt = jsu_pkg::PH_BODY;
          end else begin
            phase_nxt = jsu_pkg::PH_ERR;
          end
        end
      end
      jsu_pkg::PH_U, jsu_pkg::PH_HELD_U: begin
        if (!hx.ok) begin
          s1_en     = (ph == jsu_pkg::PH_HELD_U);
          phase_nxt = jsu_pkg::PH_ERR;
        end else begin
          acc_nxt = acc_sh;
          if (dig != 2'd3) begin
            dig_nxt = dig + 2'd1;
          end else if (ph == jsu_pkg::PH_HELD_U && lo_low) begin
            s2_en     = 1'b1;
            cp2       = 21'h10000 + {1'b0, held[9:0], acc_sh[9:0]};
            phase_nxt = jsu_pkg::PH_BODY;
          end else begin
            s1_en = (ph == jsu_pkg::PH_HELD_U);
            if (lo_high) begin
              held_nxt  = acc_sh;
              phase_nxt = jsu_pkg::PH_HELD;
            end else begin
              s2_en     = 1'b1;
              cp2       = {5'h0, acc_sh};
              phase_nxt = jsu_pkg::PH_BODY;
            end
          end
        end
      end
      default: phase_nxt = ph;
    endcase

    // buffer ended early: flush any held surrogate, then error
    if (in_last_byte && phase_nxt != jsu_pkg::PH_DONE && phase_nxt != jsu_pkg::PH_ERR) begin
      if (phase_nxt inside {jsu_pkg::PH_HELD, jsu_pkg::PH_HELD_ESC, jsu_pkg::PH_HELD_U}) begin
        s2_en = 1'b1;
        cp2   = {5'h0, held_nxt};
      end
      phase_nxt = jsu_pkg::PH_ERR;
    end

    e1   = jsu_pkg::utf8_enc({5'h0, held});
    e2   = jsu_pkg::utf8_enc(cp2);
    // plain body bytes are stored as they come, without encoding
    if (s2_raw) begin
      e2      = '0;
      e2.b[0] = in_byte;
      e2.len  = 3'd1;
    end
    len1 = s1_en ? 3'd3 : 3'd0;
    len2 = s2_en ? e2.len : 3'd0;
    ntot = len1 + len2;
    mb   = s1_en ? {e2.b[2], e2.b[1], e2.b[0], e1.b[2], e1.b[1], e1.b[0]}
                 : {16'h0, e2.b[3], e2.b[2], e2.b[1], e2.b[0]};

    stored_p1  = {1'b0, stored} + 17'd1;
    room       = (stored_p1 < {1'b0, cap}) ? ({1'b0, cap} - stored_p1) : 17'h0;
    kept       = (room >= {14'h0, ntot}) ? ntot : room[2:0];
    stored_nxt = stored + {13'h0, kept};

    push_entry.bytes  = mb;
    push_entry.cnt    = kept;
    push_entry.base   = stored;
    push_entry.status = (phase_nxt == jsu_pkg::PH_DONE) ? jsu_pkg::ST_DONE :
                        (phase_nxt == jsu_pkg::PH_ERR)  ? jsu_pkg::ST_ERR  :
                                                          jsu_pkg::ST_BUSY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= jsu_pkg::PH_SEEK;
      acc_r    <= '0;
      held_r   <= '0;
      dig_r    <= '0;
      stored_r <= '0;
    end else if (push) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      held_r   <= held_nxt;
      dig_r    <= dig_nxt;
      stored_r <= stored_nxt;
    end
  end

  `JSU_ASSERT_NEXT(a_done_sticky, phase_r == jsu_pkg::PH_DONE && !(push && in_first_byte),
                   phase_r == jsu_pkg::PH_DONE)

endmodule

>>> rtl/jsu_back.sv
`include "json_string_unescaper_top_assert.svh"

module jsu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            empty,
  input  jsu_pkg::entry_t head,
  output logic            pop,
  output logic            out_beat_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic [1:0]      out_status,
  output logic [15:0]     out_stored_length,
  output logic            out_last_result
);

  logic [2:0]  idx_r, idx_nxt;
  logic        obv_r, obv_nxt;
  logic [7:0]  byte_r;
  logic        valid_r;
  logic [1:0]  status_r;
  logic [15:0] len_r;
  logic        last_r;

  logic emit, last;

  assign emit = !empty && (!obv_r || !out_stall);
  assign last = (head.cnt == 3'd0) || (idx_r == head.cnt - 3'd1);
  assign pop  = emit && last;

  always_comb begin
    idx_nxt = idx_r;
    if (emit) begin
      idx_nxt = last ? 3'd0 : idx_r + 3'd1;
    end
    obv_nxt = emit ? 1'b1 : (obv_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      obv_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      obv_r <= obv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      valid_r  <= (head.cnt != 3'd0);
      byte_r   <= (head.cnt == 3'd0) ? 8'h00 : head.bytes[idx_r];
      status_r <= head.status;
      len_r    <= (head.cnt == 3'd0) ? head.base : head.base + {13'h0, idx_r} + 16'd1;
      last_r   <= last;
    end
  end

  assign out_beat_valid    = obv_r;
  assign out_byte          = byte_r;
  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_stored_length = len_r;
  assign out_last_result   = last_r;

  `JSU_ASSERT_NOW(a_len_nonzero, obv_r && valid_r, len_r != 16'h0)

endmodule

>>> rtl/json_string_unescaper_top.sv
// JSON string unescaper. Bytes of a buffer enter one per beat (in_first_byte opens a
// buffer, in_last_byte closes it); each input beat yields one to six output beats, the
// final one flagged by out_last_result, carrying the stored UTF-8 bytes or, when none was
// stored, one beat with out_valid low. A byte is accepted every cycle while the
// decoded-beat queue (FIFO_DEPTH entries) has room; the output side drains one beat per
// cycle while out_stall is low. cfg_wdata sets the destination capacity (reset 64);
// write it only while idle.
module json_string_unescaper_top #(
  parameter int unsigned FIFO_DEPTH = jsu_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_beat_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_beat_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_stored_length,
  output logic        out_last_result
);

  logic [15:0]     cap_r;
  logic            push, pop, full, empty;
  jsu_pkg::entry_t push_entry, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= jsu_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  jsu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cap           (cap_r),
    .in_beat_valid (in_beat_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .fifo_full     (full),
    .push          (push),
    .push_entry    (push_entry)
  );

  jsu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  jsu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (empty),
    .head              (head),
    .pop               (pop),
    .out_beat_valid    (out_beat_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_stored_length (out_stored_length),
    .out_last_result   (out_last_result)
  );

endmodule

>>> dv/tb_top.sv
module tb_top;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 6;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    status_t     status;
    logic [15:0] length;
    logic        last;
  } utf8_beat_t;

  typedef struct packed {
    logic [7:0]  c;
    logic        first;
    logic        last;
    logic        typed;
    status_t     status;
    logic [15:0] length;
  } script_row_t;

  localparam logic [7:0] WS_CHARS [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
  localparam logic [7:0] ESC_CHARS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B,
                                           CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T};
  localparam logic [15:0] CAP_PLAN [6] = '{CAP_RESET, 16'hffff, 16'd0, 16'd1, 16'd5, 16'd2};

  // typed rows carry a single beat with out_valid low
  localparam script_row_t SCRIPT [32] = '{
    '{CH_SPACE,  1'b1, 1'b0, 1'b1, ST_BUSY, 16'd0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b1, ST_BUSY, 16'd0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{CH_LC_U,   1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"d",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"8",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"0",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"0",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{CH_LC_U,   1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"D",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"C",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"0",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"0",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{CH_LC_U,   1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"D",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"B",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"F",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"F",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"x",       1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b1, ST_DONE, 16'd8},
    '{8'hff,     1'b0, 1'b0, 1'b1, ST_DONE, 16'd8},
    '{"x",       1'b1, 1'b0, 1'b1, ST_ERR,  16'd0},
    '{CH_QUOTE,  1'b1, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"q",       1'b0, 1'b0, 1'b1, ST_ERR,  16'd0},
    '{CH_QUOTE,  1'b1, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{CH_LC_U,   1'b0, 1'b0, 1'b0, ST_BUSY, 16'd0},
    '{"G",       1'b0, 1'b0, 1'b1, ST_ERR,  16'd0},
    '{CH_QUOTE,  1'b1, 1'b1, 1'b1, ST_ERR,  16'd0}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_beat_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        in_first_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_beat_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_stored_length;
  logic        out_last_result;

  json_string_unescaper_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_beat_valid     (in_beat_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_first_byte     (in_first_byte),
    .in_last_byte      (in_last_byte),
    .out_beat_valid    (out_beat_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_stored_length (out_stored_length),
    .out_last_result   (out_last_result)
  );

  // decoder model state
  phase_t      dec_phase;
  logic [1:0]  hex_pos;
  logic [15:0] hex_acc;
  logic [15:0] held_hi;
  logic [15:0] stored_cnt;
  logic [15:0] capacity;
  logic [7:0]  new_bytes [8];
  logic [15:0] new_lens [8];
  int          new_cnt;

  utf8_beat_t  expected_utf8 [$];
  logic [7:0]  text_q [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          in_gap_pct = 10;
  int          out_stall_pct = 10;
  int          added;
  logic        row_typed = 1'b0;
  status_t     row_status = ST_BUSY;
  logic [15:0] row_length = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < out_stall_pct);

  function automatic int hex_digit(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function void reset_decoder();
    capacity   = CAP_RESET;
    dec_phase  = PH_SEEK;
    hex_pos    = '0;
    hex_acc    = '0;
    held_hi    = '0;
    stored_cnt = '0;
  endfunction

  function void store_byte(logic [7:0] b);
    if (int'(stored_cnt) + 1 < int'(capacity) && new_cnt < 8) begin
      stored_cnt++;
      new_bytes[new_cnt] = b;
      new_lens[new_cnt]  = stored_cnt;
      new_cnt++;
    end
  endfunction

  function void store_code_point(int cp);
    if (cp < 'h80) begin
      store_byte(8'(cp));
    end else if (cp < 'h800) begin
      store_byte(8'('hc0 | (cp >> 6)));
      store_byte(8'('h80 | (cp & 'h3f)));
    end else if (cp < 'h10000) begin
      store_byte(8'('he0 | (cp >> 12)));
      store_byte(8'('h80 | ((cp >> 6) & 'h3f)));
      store_byte(8'('h80 | (cp & 'h3f)));
    end else begin
      store_byte(8'('hf0 | (cp >> 18)));
      store_byte(8'('h80 | ((cp >> 12) & 'h3f)));
      store_byte(8'('h80 | ((cp >> 6) & 'h3f)));
      store_byte(8'('h80 | (cp & 'h3f)));
    end
  endfunction

  function void body_char(logic [7:0] c);
    if (c == CH_QUOTE) dec_phase = PH_DONE;
    else if (c == CH_BSLASH) dec_phase = PH_ESC;
    else store_byte(c);
  endfunction

  function void escape_char(logic [7:0] c);
    dec_phase = PH_BODY;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: store_byte(c);
      CH_LC_B: store_byte(CH_BS);
      CH_LC_F: store_byte(CH_FF);
      CH_LC_N: store_byte(CH_LF);
      CH_LC_R: store_byte(CH_CR);
      CH_LC_T: store_byte(CH_TAB);
      CH_LC_U: begin
        hex_acc   = '0;
        hex_pos   = '0;
        dec_phase = PH_U;
      end
      default: dec_phase = PH_ERR;
    endcase
  endfunction

  function void take_code(logic [15:0] v);
    if (v >= 16'hd800 && v <= 16'hdbff) begin
      held_hi   = v;
      dec_phase = PH_HELD;
    end else begin
      store_code_point(int'(v));
      dec_phase = PH_BODY;
    end
  endfunction

  // decodes one input byte and queues the beats it must produce; returns their count
  function int unescape_byte(logic [7:0] c, logic first, logic last);
    int      d;
    int      n;
    int      i;
    status_t st;
    d = hex_digit(c);
    new_cnt = 0;
    if (first) begin
      dec_phase  = PH_SEEK;
      hex_pos    = '0;
      hex_acc    = '0;
      held_hi    = '0;
      stored_cnt = '0;
    end
    case (dec_phase)
      PH_SEEK: begin
        if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)) begin
          if (c == CH_QUOTE && capacity != 0) dec_phase = PH_BODY;
          else dec_phase = PH_ERR;
        end
      end
      PH_BODY: body_char(c);
      PH_ESC: escape_char(c);
      PH_U, PH_HELD_U: begin
        if (d < 0) begin
          if (dec_phase == PH_HELD_U) store_code_point(int'(held_hi));
          dec_phase = PH_ERR;
        end else begin
          hex_acc = {hex_acc[11:0], 4'(d)};
          if (hex_pos != 2'd3) begin
            hex_pos++;
          end else if (dec_phase == PH_U) begin
            take_code(hex_acc);
          end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
            store_code_point('h10000 + ((int'(held_hi) - 'hd800) << 10)
                             + (int'(hex_acc) - 'hdc00));
            dec_phase = PH_BODY;
          end else begin
            store_code_point(int'(held_hi));
            take_code(hex_acc);
          end
        end
      end
      PH_HELD: begin
        if (c == CH_BSLASH) begin
          dec_phase = PH_HELD_ESC;
        end else begin
          store_code_point(int'(held_hi));
          dec_phase = PH_BODY;
          body_char(c);
        end
      end
      PH_HELD_ESC: begin
        if (c == CH_LC_U) begin
          hex_acc   = '0;
          hex_pos   = '0;
          dec_phase = PH_HELD_U;
        end else begin
          store_code_point(int'(held_hi));
          escape_char(c);
        end
      end
      default: ;
    endcase
    if (last && dec_phase != PH_DONE && dec_phase != PH_ERR) begin
      if (dec_phase inside {PH_HELD, PH_HELD_ESC, PH_HELD_U}) store_code_point(int'(held_hi));
      dec_phase = PH_ERR;
    end
    st = (dec_phase == PH_DONE) ? ST_DONE : (dec_phase == PH_ERR) ? ST_ERR : ST_BUSY;
    if (new_cnt == 0) begin
      expected_utf8.push_back(utf8_beat_t'{8'h00, 1'b0, st, stored_cnt, 1'b1});
      return 1;
    end
    n = (new_cnt > MAX_OUT) ? MAX_OUT : new_cnt;
    for (i = 0; i < n; i++)
      expected_utf8.push_back(utf8_beat_t'{new_bytes[i], 1'b1, st, new_lens[i], i == n - 1});
    return n;
  endfunction

  function void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_beat();
    utf8_beat_t want;
    if (expected_utf8.size() == 0) begin
      $error("unexpected result beat: out_byte %0h out_status %0h", out_byte, out_status);
      mismatches++;
    end else begin
      want = expected_utf8.pop_front();
      check_field("out_byte", 16'(want.data), 16'(out_byte));
      check_field("out_valid", 16'(want.valid), 16'(out_valid));
      check_field("out_status", 16'(want.status), 16'(out_status));
      check_field("out_stored_length", want.length, out_stored_length);
      check_field("out_last_result", 16'(want.last), 16'(out_last_result));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_decoder();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (in_beat_valid && !in_stall) begin
        added = unescape_byte(in_byte, in_first_byte, in_last_byte);
        if (row_typed) begin
          repeat (added) void'(expected_utf8.pop_back());
          expected_utf8.push_back(utf8_beat_t'{8'h00, 1'b0, row_status, row_length, 1'b1});
        end
      end
      if (out_beat_valid && !out_stall) check_beat();
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(logic [7:0] b, logic first, logic last);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_beat_valid <= 1'b0;
      @(negedge clk);
    end
    in_byte       <= b;
    in_first_byte <= first;
    in_last_byte  <= last;
    in_beat_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_capacity(logic [15:0] v);
    in_beat_valid <= 1'b0;
    while (expected_utf8.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    do ch = $urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7e)) : 8'($urandom());
    while (ch == CH_QUOTE || ch == CH_BSLASH);
    return ch;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] ch;
    do ch = 8'($urandom());
    while (hex_digit(ch) >= 0);
    return ch;
  endfunction

  function void put_uescape(logic [15:0] v);
    int i;
    text_q.push_back(CH_BSLASH);
    text_q.push_back(CH_LC_U);
    for (i = 3; i >= 0; i--) text_q.push_back(hex_char(v[i*4 +: 4]));
  endfunction

  function void put_simple_escape();
    text_q.push_back(CH_BSLASH);
    text_q.push_back(ESC_CHARS[$urandom_range(0, 7)]);
  endfunction

  task automatic send_string();
    int          broken;
    int          i;
    logic [15:0] hi;
    logic        end_flag;
    text_q.delete();
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3))
        send_beat(8'($urandom()), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
    broken = ($urandom_range(0, 99) < 20) ? int'($urandom_range(0, 3)) : -1;
    repeat ($urandom_range(0, 2)) text_q.push_back(WS_CHARS[$urandom_range(0, 3)]);
    if (broken == 2) text_q.push_back(plain_char());
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      hi = 16'hd800 | 16'($urandom_range(0, 1023));
      case ($urandom_range(0, 6))
        0, 1: text_q.push_back(plain_char());
        2: put_simple_escape();
        3: put_uescape(16'($urandom()));
        4: begin
          put_uescape(hi);
          put_uescape(16'hdc00 | 16'($urandom_range(0, 1023)));
        end
        5: begin
          put_uescape(hi);
          text_q.push_back(plain_char());
        end
        default: begin
          put_uescape(hi);
          if ($urandom_range(0, 1)) put_simple_escape();
          else put_uescape(16'($urandom()));
        end
      endcase
    end
    case (broken)
      0: begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(8'($urandom()));
      end
      1: begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_LC_U);
        repeat ($urandom_range(0, 3)) text_q.push_back(hex_char(4'($urandom())));
        text_q.push_back(bad_hex_char());
      end
      3: ;
      default: begin
        text_q.push_back(CH_QUOTE);
        if ($urandom_range(0, 4) == 0) text_q.push_back(8'($urandom()));
      end
    endcase
    end_flag = ($urandom_range(0, 9) != 0) || broken == 3;
    for (i = 0; i < text_q.size(); i++) begin
      send_beat(text_q[i], i == 0, end_flag && i == text_q.size() - 1);
      items_sent++;
    end
  endtask

  initial begin
    int p;
    int i;
    int target;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (i = 0; i < $size(SCRIPT); i++) begin
      row_typed  = SCRIPT[i].typed;
      row_status = SCRIPT[i].status;
      row_length = SCRIPT[i].length;
      send_beat(SCRIPT[i].c, SCRIPT[i].first, SCRIPT[i].last);
    end
    row_typed = 1'b0;
    for (p = 0; p < $size(CAP_PLAN); p++) begin
      if (p != 0) set_capacity(CAP_PLAN[p]);
      in_gap_pct    = (p == 1) ? 0 : 10;
      out_stall_pct = (p == 1) ? 0 : 10;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_string();
    end
    in_beat_valid <= 1'b0;
    while (expected_utf8.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_utf8.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
